// ===== sv/dmaq_pkg.sv =====
// Package for the DMA descriptor ring queue: field widths, command and
// status codes, the descriptor type and the cell control group.
// No dependencies.
package dmaq_pkg;

  localparam int QUEUE_DEPTH_DEF = 8;
  localparam int MAX_ITEMS_DEF   = 1024;

  localparam int CMD_W    = 2;
  localparam int ADDR_W   = 32;
  localparam int ICNT_W   = 16;
  localparam int WSIZE_W  = 3;
  localparam int STAT_W   = 2;
  localparam int COUNT_W  = 11;
  localparam int WCODE_W  = 2;
  localparam int QLEVEL_W = 4;
  localparam int TOTAL_W  = 32;

  localparam logic [CMD_W-1:0] CMD_SUBMIT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DONE   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ERROR  = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK         = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL       = 2'd1;
  localparam logic [STAT_W-1:0] STAT_ARG_ERR    = 2'd2;
  localparam logic [STAT_W-1:0] STAT_DONE_EMPTY = 2'd3;

  localparam logic [WSIZE_W-1:0] WSIZE_BYTE = 3'd1;
  localparam logic [WSIZE_W-1:0] WSIZE_HALF = 3'd2;
  localparam logic [WSIZE_W-1:0] WSIZE_WORD = 3'd4;

  localparam logic [WCODE_W-1:0] WCODE_BYTE = 2'd0;
  localparam logic [WCODE_W-1:0] WCODE_HALF = 2'd1;
  localparam logic [WCODE_W-1:0] WCODE_WORD = 2'd2;

  typedef struct packed {
    logic [ADDR_W-1:0]  src_end;
    logic [COUNT_W-1:0] count;
    logic [WCODE_W-1:0] width;
  } desc_t;

  typedef struct packed {
    logic shift;  // take the neighbor's descriptor
    logic load;   // take the newly submitted descriptor
  } cell_ctl_t;

endpackage

// ===== sv/dmaq_if.sv =====
// Channel interfaces of the DMA descriptor ring queue: submit/event beats in,
// result beats out. Depends on dmaq_pkg.
interface dmaq_in_if import dmaq_pkg::*; ;
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [ADDR_W-1:0]  start_addr;
  logic [ICNT_W-1:0]  item_count;
  logic [WSIZE_W-1:0] word_size;

  modport source (output valid, cmd, start_addr, item_count, word_size, input ready);
  modport sink   (input valid, cmd, start_addr, item_count, word_size, output ready);
endinterface

interface dmaq_out_if import dmaq_pkg::*; ;
  logic                valid;
  logic                ready;
  logic [STAT_W-1:0]   status;
  logic                launch;
  logic [ADDR_W-1:0]   launch_src_end;
  logic [COUNT_W-1:0]  launch_count;
  logic [WCODE_W-1:0]  launch_width;
  logic [QLEVEL_W-1:0] queue_level;
  logic                error_flag;
  logic [TOTAL_W-1:0]  transfer_total;

  modport source (output valid, status, launch, launch_src_end, launch_count,
                  launch_width, queue_level, error_flag, transfer_total,
                  input ready);
  modport sink   (input valid, status, launch, launch_src_end, launch_count,
                  launch_width, queue_level, error_flag, transfer_total,
                  output ready);
endinterface

// ===== sv/dmaq_cell.sv =====
// One cell of the pending-descriptor chain: holds one descriptor, loads a
// new one or takes its neighbor's on a pop. Depends on dmaq_pkg.
module dmaq_cell
  import dmaq_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  desc_t     new_desc,
  input  desc_t     nbr_desc,
  output desc_t     desc
);

  desc_t desc_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      desc_r <= new_desc;
    end else if (ctl.shift) begin
      desc_r <= nbr_desc;
    end
  end

  assign desc = desc_r;

endmodule

// ===== sv/dma_descriptor_ring_queue_top.sv =====
// Top level of the DMA descriptor ring queue: command decode, level and
// total counters, result register and the chain of pending cells.
// Depends on dmaq_pkg, dmaq_if and dmaq_cell.
//
//  channel | dir | beat content                                  | handshake
//  --------+-----+-----------------------------------------------+-----------
//  in_ch   | in  | cmd, start_addr, item_count, word_size        | valid/ready
//  out_ch  | out | status, launch + descriptor, level, flag, total | valid/ready
//
// One beat per cycle: each input beat is decoded and resolved in the cycle it
// is accepted, and its result lands in the output register on the same edge.
// in_ch.ready is high out of reset while the output register is empty or being
// drained, so a stalled out_ch holds one finished result and stops intake only
// then.
// Reset (rst_n low, synchronous) empties the queue, clears level, total and
// the sticky error flag; stored descriptors are not cleared. No beat is taken
// while rst_n is low.
// The running descriptor is not held: the cells keep only the ones still
// waiting, and a done beat with a descriptor waiting shifts the whole chain one cell toward cell 0.
module dma_descriptor_ring_queue_top
  import dmaq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int MAX_ITEMS   = MAX_ITEMS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  dmaq_in_if.sink    in_ch,
  dmaq_out_if.source out_ch
);

  localparam int LVL_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int PEND_N = QUEUE_DEPTH - 1;  // waiting slots behind the running one

  // Control state
  logic [LVL_W-1:0]   level_r, level_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic               err_r, err_nxt;
  logic               out_valid_r;

  // Result register (payload, no reset)
  logic [STAT_W-1:0]   out_status_r, status_nxt;
  logic                out_launch_r, launch_nxt;
  desc_t               out_desc_r, launch_desc_nxt;
  logic [QLEVEL_W-1:0] out_level_r;

  logic in_fire;
  logic size_ok, cnt_ok, full;
  logic [WCODE_W-1:0] wcode;
  logic [ADDR_W-1:0]  span;
  desc_t new_desc;
  logic push, pop;

  cell_ctl_t cell_ctl [PEND_N];
  desc_t     cell_desc [PEND_N];

  assign in_ch.ready = rst_n && (!out_valid_r || out_ch.ready);
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Argument check and descriptor build
  always_comb begin
    size_ok = 1'b1;
    wcode   = WCODE_BYTE;
    case (in_ch.word_size)
      WSIZE_BYTE: wcode = WCODE_BYTE;
      WSIZE_HALF: wcode = WCODE_HALF;
      WSIZE_WORD: wcode = WCODE_WORD;
      default:    size_ok = 1'b0;
    endcase
    cnt_ok = (in_ch.item_count != '0) && (in_ch.item_count <= ICNT_W'(MAX_ITEMS));
    // count * size is a shift by the width code
    span = ADDR_W'(in_ch.item_count) << wcode;
    new_desc.src_end = in_ch.start_addr + span - ADDR_W'(1);
    new_desc.count   = in_ch.item_count[COUNT_W-1:0];
    new_desc.width   = wcode;
    full = (level_r >= LVL_W'(QUEUE_DEPTH));
  end

  // Command resolution
  always_comb begin
    level_nxt       = level_r;
    total_nxt       = total_r;
    err_nxt         = err_r;
    status_nxt      = STAT_OK;
    launch_nxt      = 1'b0;
    launch_desc_nxt = '0;
    push            = 1'b0;
    pop             = 1'b0;
    case (in_ch.cmd)
      CMD_SUBMIT: begin
        if (!cnt_ok || !size_ok) begin
          status_nxt = STAT_ARG_ERR;
        end else if (full) begin
          status_nxt = STAT_FULL;
        end else begin
          if (level_r == '0) begin
            launch_nxt      = 1'b1;   // idle channel: hand it over at once
            launch_desc_nxt = new_desc;
          end else begin
            push = 1'b1;
          end
          level_nxt = level_r + LVL_W'(1);
          total_nxt = total_r + TOTAL_W'(1);
        end
      end
      CMD_DONE: begin
        if (level_r == '0) begin
          status_nxt = STAT_DONE_EMPTY;
        end else begin
          level_nxt = level_r - LVL_W'(1);
          if (level_r > LVL_W'(1)) begin
            launch_nxt      = 1'b1;
            launch_desc_nxt = cell_desc[0];
            pop             = 1'b1;
          end
        end
      end
      CMD_ERROR: begin
        level_nxt = '0;
        total_nxt = '0;
        err_nxt   = 1'b1;
      end
      default: begin
        status_nxt = STAT_ARG_ERR;
      end
    endcase
  end

  // Pending chain: waiting count is level - 1; a push lands right behind the
  // last waiting descriptor.
  for (genvar i = 0; i < PEND_N; i++) begin : g_cell
    assign cell_ctl[i].shift = in_fire && pop;
    assign cell_ctl[i].load  = in_fire && push && (level_r == LVL_W'(i + 1));

    dmaq_cell u_cell (
      .clk      (clk),
      .ctl      (cell_ctl[i]),
      .new_desc (new_desc),
      .nbr_desc ((i == PEND_N - 1) ? cell_desc[i] : cell_desc[(i + 1) % PEND_N]),
      .desc     (cell_desc[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r     <= '0;
      total_r     <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        level_r     <= level_nxt;
        total_r     <= total_nxt;
        err_r       <= err_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_status_r <= status_nxt;
      out_launch_r <= launch_nxt;
      out_desc_r   <= launch_desc_nxt;
      out_level_r  <= QLEVEL_W'(level_nxt);
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.launch         = out_launch_r;
  assign out_ch.launch_src_end = out_desc_r.src_end;
  assign out_ch.launch_count   = out_desc_r.count;
  assign out_ch.launch_width   = out_desc_r.width;
  assign out_ch.queue_level    = out_level_r;
  assign out_ch.error_flag     = err_r;
  assign out_ch.transfer_total = total_r;

endmodule
